@@ rtl/mtep_pkg.sv @@
// Shared types and constants for the MIDI track event parser.
// No dependencies; used by midi_track_event_parser_top.
package mtep_pkg;

  // Event kind codes carried on event_kind
  localparam logic [3:0] KIND_NOTE_OFF   = 4'd0;
  localparam logic [3:0] KIND_SEQNUM     = 4'd7;
  localparam logic [3:0] KIND_METABYTE   = 4'd8;
  localparam logic [3:0] KIND_ENDTRACK   = 4'd9;
  localparam logic [3:0] KIND_ERROR      = 4'd10;

  // Byte values that steer parsing
  localparam logic [7:0] STATUS_META     = 8'hFF;
  localparam logic [7:0] STATUS_SYSTEM   = 8'hF0;
  localparam logic [7:0] META_SEQNUM     = 8'h00;
  localparam logic [7:0] META_TRACK_NAME = 8'h03;
  localparam logic [7:0] META_END_TRACK  = 8'h2F;
  localparam logic [3:0] HI_PROGRAM      = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS   = 4'hD;
  localparam logic [3:0] HI_NOTE_OFF     = 4'h8;
  localparam logic [3:0] HI_PITCH_BEND   = 4'hE;

  // Longest variable-length quantity, in bytes
  localparam logic [2:0] VLQ_MAX_BYTES   = 3'd4;

  // One decoded event word
  typedef struct packed {
    logic [3:0]  kind;
    logic [27:0] delta;
    logic [3:0]  chan;
    logic [6:0]  first;
    logic [6:0]  second;
    logic [15:0] wide;
    logic [7:0]  mtype;
    logic [7:0]  pbyte;
  } event_t;

endpackage

@@ rtl/midi_track_event_parser_top.sv @@
// MIDI track event parser: delta time, running status, meta events.
// Depends on mtep_pkg (event kind codes, constants, event_t).
//
// Channel  Dir  Handshake               Word fields
// in       in   in_valid_i/in_stall_o   data_byte_i, track_start_i
// out      out  out_valid_o/out_stall_i event_kind_o, delta_time_o, channel_o,
//                                       first_data_o, second_data_o,
//                                       wide_value_o, meta_code_o, payload_byte_o
//
// One byte per cycle while in_stall_o is low. Each accepted byte updates the
// parser registers and, when it completes an event, loads the output register
// in the same edge; the event shows in the cycle after its last byte.
// in_stall_o rises only while a held output word is stalled, so input and
// output overlap freely. rst_ni (async, active low) clears all parser state;
// track_start_i does the same for the byte it comes with.
module midi_track_event_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        track_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  event_kind_o,
  output logic [27:0] delta_time_o,
  output logic [3:0]  channel_o,
  output logic [6:0]  first_data_o,
  output logic [6:0]  second_data_o,
  output logic [15:0] wide_value_o,
  output logic [7:0]  meta_code_o,
  output logic [7:0]  payload_byte_o
);

  // Parse phase codes
  localparam logic [2:0] PH_DELTA  = 3'd0;
  localparam logic [2:0] PH_STATUS = 3'd1;
  localparam logic [2:0] PH_DATA1  = 3'd2;
  localparam logic [2:0] PH_DATA2  = 3'd3;
  localparam logic [2:0] PH_MTYPE  = 3'd4;
  localparam logic [2:0] PH_MLEN   = 3'd5;
  localparam logic [2:0] PH_MDATA  = 3'd6;
  localparam logic [2:0] PH_ENDED  = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [27:0] delta_q, delta_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  rs_q, rs_d;
  logic [6:0]  held_first_q, held_first_d;
  logic [7:0]  held_mt_q, held_mt_d;
  logic [27:0] remain_q, remain_d;
  logic [7:0]  high_q, high_d;
  logic        halted_q, halted_d;

  logic            out_valid_q, out_valid_d;
  mtep_pkg::event_t res_q, res_d;

  logic accept;
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Parser state as seen by this byte (track start wipes it first)
  logic [2:0]  e_phase;
  logic [27:0] e_delta;
  logic [2:0]  e_cnt;
  logic [7:0]  e_rs;
  logic [6:0]  e_held_first;
  logic [7:0]  e_held_mt;
  logic [27:0] e_remain;
  logic [7:0]  e_high;
  logic        e_halted;

  always_comb begin
    if (track_start_i) begin
      e_phase = PH_DELTA;  e_delta = '0;  e_cnt = '0;  e_rs = '0;
      e_held_first = '0;   e_held_mt = '0; e_remain = '0; e_high = '0;
      e_halted = 1'b0;
    end else begin
      e_phase = phase_q;   e_delta = delta_q;  e_cnt = cnt_q;  e_rs = rs_q;
      e_held_first = held_first_q; e_held_mt = held_mt_q;
      e_remain = remain_q; e_high = high_q; e_halted = halted_q;
    end
  end

  logic [6:0]  low7;
  logic [2:0]  cnt_inc;
  logic [27:0] vlq_delta, vlq_remain, remain_dec;
  logic [3:0]  rs_hi;
  logic        emit, fail;
  mtep_pkg::event_t ev;

  assign low7       = data_byte_i[6:0];
  assign cnt_inc    = e_cnt + 3'd1;
  assign vlq_delta  = {e_delta[20:0], low7};
  assign vlq_remain = {e_remain[20:0], low7};
  assign remain_dec = e_remain - 28'd1;
  assign rs_hi      = e_rs[7:4];

  always_comb begin
    phase_d = e_phase;  delta_d = e_delta;  cnt_d = e_cnt;  rs_d = e_rs;
    held_first_d = e_held_first;  held_mt_d = e_held_mt;
    remain_d = e_remain;  high_d = e_high;  halted_d = e_halted;
    emit = 1'b0;
    fail = 1'b0;
    ev   = '0;
    ev.delta = e_delta;

    if (!e_halted) begin
      case (e_phase)
        PH_DELTA: begin
          delta_d = vlq_delta;
          cnt_d   = cnt_inc;
          if (data_byte_i[7]) begin
            if (cnt_inc >= mtep_pkg::VLQ_MAX_BYTES) fail = 1'b1;
          end else begin
            phase_d = PH_STATUS;
          end
        end
        PH_STATUS, PH_DATA1: begin
          if (e_phase == PH_STATUS && data_byte_i == mtep_pkg::STATUS_META) begin
            rs_d    = '0;
            phase_d = PH_MTYPE;
          end else if (e_phase == PH_STATUS && data_byte_i >= mtep_pkg::STATUS_SYSTEM) begin
            fail = 1'b1;
          end else if (e_phase == PH_STATUS && data_byte_i[7]) begin
            rs_d    = data_byte_i;
            phase_d = PH_DATA1;
          end else if (e_phase == PH_STATUS && e_rs == 8'd0) begin
            fail = 1'b1;
          end else if (rs_hi == mtep_pkg::HI_PROGRAM || rs_hi == mtep_pkg::HI_CHAN_PRESS) begin
            // one-data-byte channel event
            emit     = 1'b1;
            ev.kind  = rs_hi - mtep_pkg::HI_NOTE_OFF;
            ev.chan  = e_rs[3:0];
            ev.first = low7;
            phase_d  = PH_DELTA;
            delta_d  = '0;
            cnt_d    = '0;
          end else begin
            held_first_d = low7;
            phase_d      = PH_DATA2;
          end
        end
        PH_DATA2: begin
          emit      = 1'b1;
          ev.kind   = (rs_hi >= mtep_pkg::HI_NOTE_OFF) ? rs_hi - mtep_pkg::HI_NOTE_OFF
                                                       : mtep_pkg::KIND_NOTE_OFF;
          ev.chan   = e_rs[3:0];
          ev.first  = e_held_first;
          ev.second = low7;
          if (rs_hi == mtep_pkg::HI_PITCH_BEND) ev.wide = {2'b00, low7, e_held_first};
          phase_d   = PH_DELTA;
          delta_d   = '0;
          cnt_d     = '0;
        end
        PH_MTYPE: begin
          held_mt_d = data_byte_i;
          high_d    = '0;
          remain_d  = '0;
          cnt_d     = '0;
          phase_d   = PH_MLEN;
        end
        PH_MLEN: begin
          remain_d = vlq_remain;
          cnt_d    = cnt_inc;
          if (data_byte_i[7]) begin
            if (cnt_inc >= mtep_pkg::VLQ_MAX_BYTES) fail = 1'b1;
          end else if (vlq_remain != 28'd0) begin
            phase_d = PH_MDATA;
          end else if (e_held_mt == mtep_pkg::META_END_TRACK) begin
            emit     = 1'b1;
            ev.kind  = mtep_pkg::KIND_ENDTRACK;
            ev.mtype = e_held_mt;
            phase_d  = PH_ENDED;
          end else begin
            phase_d = PH_DELTA;
            delta_d = '0;
            cnt_d   = '0;
          end
        end
        PH_MDATA: begin
          remain_d = remain_dec;
          if (e_held_mt == mtep_pkg::META_TRACK_NAME) begin
            emit     = 1'b1;
            ev.kind  = mtep_pkg::KIND_METABYTE;
            ev.mtype = e_held_mt;
            ev.pbyte = data_byte_i;
          end else if (e_held_mt == mtep_pkg::META_SEQNUM) begin
            // value is the last two payload bytes, high first
            if (remain_dec == 28'd0) begin
              emit     = 1'b1;
              ev.kind  = mtep_pkg::KIND_SEQNUM;
              ev.mtype = e_held_mt;
              ev.wide  = {e_high, data_byte_i};
            end
            high_d = data_byte_i;
          end
          if (remain_dec == 28'd0) begin
            if (e_held_mt == mtep_pkg::META_END_TRACK) begin
              emit     = 1'b1;
              ev       = '0;
              ev.delta = e_delta;
              ev.kind  = mtep_pkg::KIND_ENDTRACK;
              ev.mtype = e_held_mt;
              phase_d  = PH_ENDED;
            end else begin
              phase_d = PH_DELTA;
              delta_d = '0;
              cnt_d   = '0;
            end
          end
        end
        default: begin
          // after end of track: ignore bytes until track start
        end
      endcase

      if (fail) begin
        halted_d = 1'b1;
        delta_d  = '0;
        emit     = 1'b1;
        ev       = '0;
        ev.kind  = mtep_pkg::KIND_ERROR;
      end
    end
  end

  // Output register: loads on an accepted byte that finishes an event
  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    res_d       = res_q;
    if (accept && emit) begin
      out_valid_d = 1'b1;
      res_d       = ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_DELTA;
      delta_q      <= '0;
      cnt_q        <= '0;
      rs_q         <= '0;
      held_first_q <= '0;
      held_mt_q    <= '0;
      remain_q     <= '0;
      high_q       <= '0;
      halted_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        phase_q      <= phase_d;
        delta_q      <= delta_d;
        cnt_q        <= cnt_d;
        rs_q         <= rs_d;
        held_first_q <= held_first_d;
        held_mt_q    <= held_mt_d;
        remain_q     <= remain_d;
        high_q       <= high_d;
        halted_q     <= halted_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = res_q.kind;
  assign delta_time_o   = res_q.delta;
  assign channel_o      = res_q.chan;
  assign first_data_o   = res_q.first;
  assign second_data_o  = res_q.second;
  assign wide_value_o   = res_q.wide;
  assign meta_code_o    = res_q.mtype;
  assign payload_byte_o = res_q.pbyte;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for midi_track_event_parser_top: track bytes in, decoded events out.
// Depends on mtep_pkg for the event codes, steering bytes and event_t.
module testbench;

  localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int TAIL_CYCLES    = 8;     // settle time after the last event
  localparam logic [7:0] STATUS_LAST_SYSTEM = 8'hFE;

  typedef enum logic [2:0] {
    AWAIT_DELTA, AWAIT_STATUS, AWAIT_DATA1, AWAIT_DATA2,
    AWAIT_META_TYPE, AWAIT_META_LEN, IN_META_DATA, TRACK_ENDED
  } parse_phase_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        track_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  event_kind;
  logic [27:0] delta_time;
  logic [3:0]  channel;
  logic [6:0]  first_data;
  logic [6:0]  second_data;
  logic [15:0] wide_value;
  logic [7:0]  meta_code;
  logic [7:0]  payload_byte;

  // Parser state as the testbench tracks it
  parse_phase_e trk_phase;
  logic [27:0]  trk_delta;
  logic [2:0]   trk_vlq_len;
  logic [7:0]   trk_running;
  logic [6:0]   trk_held_d1;
  logic [7:0]   trk_meta_code;
  logic [27:0]  trk_meta_left;
  logic [7:0]   trk_seq_hi;
  logic         trk_halted;

  mtep_pkg::event_t pending_events[$];

  // Stimulus controls
  bit tx_gaps = 1'b0;
  bit rx_random = 1'b0;
  bit new_track = 1'b0;  // next byte carries track_start
  int rx_hold_req = 0;
  int rx_stall_left = 0;

  int mismatches = 0;
  int bytes_sent = 0;
  int tracks_started = 0;
  int events_checked = 0;
  int error_events = 0;
  int idle_cycles = 0;

  midi_track_event_parser_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .track_start_i  (track_start),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .event_kind_o   (event_kind),
    .delta_time_o   (delta_time),
    .channel_o      (channel),
    .first_data_o   (first_data),
    .second_data_o  (second_data),
    .wide_value_o   (wide_value),
    .meta_code_o    (meta_code),
    .payload_byte_o (payload_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  task automatic clear_track_state();
    trk_phase     = AWAIT_DELTA;
    trk_delta     = '0;
    trk_vlq_len   = '0;
    trk_running   = '0;
    trk_held_d1   = '0;
    trk_meta_code = '0;
    trk_meta_left = '0;
    trk_seq_hi    = '0;
    trk_halted    = 1'b0;
  endtask

  task automatic queue_event(input logic [3:0] kind, input logic [3:0] ch,
                             input logic [6:0] d1, input logic [6:0] d2,
                             input logic [15:0] wide, input logic [7:0] mt,
                             input logic [7:0] pb);
    mtep_pkg::event_t ev;
    ev.kind   = kind;
    ev.delta  = trk_delta;
    ev.chan   = ch;
    ev.first  = d1;
    ev.second = d2;
    ev.wide   = wide;
    ev.mtype  = mt;
    ev.pbyte  = pb;
    pending_events.push_back(ev);
  endtask

  task automatic start_next_event();
    trk_phase   = AWAIT_DELTA;
    trk_delta   = '0;
    trk_vlq_len = '0;
  endtask

  // Error word carries zero delta; parser stays dead until the next track start
  task automatic halt_with_error();
    trk_halted = 1'b1;
    trk_delta  = '0;
    queue_event(mtep_pkg::KIND_ERROR, '0, '0, '0, '0, '0, '0);
  endtask

  task automatic take_first_data(input logic [7:0] b);
    logic [3:0] hi;
    hi = trk_running[7:4];
    if (hi == mtep_pkg::HI_PROGRAM || hi == mtep_pkg::HI_CHAN_PRESS) begin
      queue_event(mtep_pkg::KIND_NOTE_OFF + (hi - mtep_pkg::HI_NOTE_OFF), trk_running[3:0],
                  b[6:0], '0, '0, '0, '0);
      start_next_event();
    end else begin
      trk_held_d1 = b[6:0];
      trk_phase   = AWAIT_DATA2;
    end
  endtask

  // Meta length ran out: end of track stops the track, anything else moves on
  task automatic finish_meta();
    if (trk_meta_code == mtep_pkg::META_END_TRACK) begin
      queue_event(mtep_pkg::KIND_ENDTRACK, '0, '0, '0, '0, trk_meta_code, '0);
      trk_phase = TRACK_ENDED;
    end else begin
      start_next_event();
    end
  endtask

  task automatic decode_track_byte(input logic [7:0] b, input logic ts);
    logic [3:0] hi;
    if (ts)
      clear_track_state();
    if (trk_halted)
      return;
    hi = trk_running[7:4];
    case (trk_phase)
      AWAIT_DELTA: begin
        trk_delta = {trk_delta[20:0], b[6:0]};
        trk_vlq_len++;
        if (!b[7])
          trk_phase = AWAIT_STATUS;
        else if (trk_vlq_len >= mtep_pkg::VLQ_MAX_BYTES)
          halt_with_error();
      end
      AWAIT_STATUS: begin
        if (b == mtep_pkg::STATUS_META) begin
          trk_running = '0;
          trk_phase   = AWAIT_META_TYPE;
        end else if (b >= mtep_pkg::STATUS_SYSTEM) begin
          halt_with_error();
        end else if (b[7]) begin
          trk_running = b;
          trk_phase   = AWAIT_DATA1;
        end else if (trk_running == '0) begin
          halt_with_error();
        end else begin
          take_first_data(b);
        end
      end
      AWAIT_DATA1: take_first_data(b);
      AWAIT_DATA2: begin
        // bend packs LSB first: wide = MSB*128 + LSB
        queue_event(mtep_pkg::KIND_NOTE_OFF + (hi - mtep_pkg::HI_NOTE_OFF), trk_running[3:0],
                    trk_held_d1, b[6:0],
                    (hi == mtep_pkg::HI_PITCH_BEND) ? {2'b00, b[6:0], trk_held_d1} : 16'h0000,
                    '0, '0);
        start_next_event();
      end
      AWAIT_META_TYPE: begin
        trk_meta_code = b;
        trk_seq_hi    = '0;
        trk_meta_left = '0;
        trk_vlq_len   = '0;
        trk_phase     = AWAIT_META_LEN;
      end
      AWAIT_META_LEN: begin
        trk_meta_left = {trk_meta_left[20:0], b[6:0]};
        trk_vlq_len++;
        if (b[7]) begin
          if (trk_vlq_len >= mtep_pkg::VLQ_MAX_BYTES)
            halt_with_error();
        end else if (trk_meta_left != '0) begin
          trk_phase = IN_META_DATA;
        end else begin
          finish_meta();
        end
      end
      IN_META_DATA: begin
        trk_meta_left--;
        if (trk_meta_code == mtep_pkg::META_TRACK_NAME) begin
          queue_event(mtep_pkg::KIND_METABYTE, '0, '0, '0, '0, trk_meta_code, b);
        end else if (trk_meta_code == mtep_pkg::META_SEQNUM) begin
          // value is the last two payload bytes, high byte first
          if (trk_meta_left == '0)
            queue_event(mtep_pkg::KIND_SEQNUM, '0, '0, '0, {trk_seq_hi, b}, trk_meta_code,
                        '0);
          trk_seq_hi = b;
        end
        if (trk_meta_left == '0)
          finish_meta();
      end
      default: ;  // track ended: ignore until track start
    endcase
  endtask

  // ---------------------------------------------------------------- sender

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Drives one word at the falling edge and holds it until accepted
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    track_start <= new_track;
    do @(posedge clk); while (in_stall);
    decode_track_byte(b, new_track);
    if (new_track)
      tracks_started++;
    new_track = 1'b0;
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sender pause: nothing offered until every predicted event is back
  task automatic wait_for_events();
    in_valid <= 1'b0;
    while (pending_events.size() != 0)
      @(negedge clk);
  endtask

  function automatic int unsigned pick_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 75) return $urandom_range(1, 127);
    if (r < 88) return $urandom_range(128, 16383);
    if (r < 96) return $urandom_range(16384, 2097151);
    return $urandom_range(2097152, 28'hFFFFFFF);
  endfunction

  function automatic logic [7:0] rand_data();
    if ($urandom_range(0, 9) == 0)
      return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  // Variable-length quantity, now and then with a redundant leading group
  task automatic send_vlq(input int unsigned val);
    int nb;
    nb = 1;
    while (nb < mtep_pkg::VLQ_MAX_BYTES && (val >> (7 * nb)) != 0)
      nb++;
    if (nb < mtep_pkg::VLQ_MAX_BYTES && $urandom_range(0, 9) == 0)
      nb++;
    for (int i = nb - 1; i >= 0; i--)
      send_byte({i != 0, 7'(val >> (7 * i))});
  endtask

  task automatic send_channel_event();
    logic [3:0] hi;
    send_vlq(pick_delta());
    if (trk_running != '0 && $urandom_range(0, 2) == 0) begin
      // running status: first data must not look like a status byte
      hi = trk_running[7:4];
      send_byte(8'($urandom_range(0, 127)));
    end else begin
      hi = 4'($urandom_range(mtep_pkg::HI_NOTE_OFF, mtep_pkg::HI_PITCH_BEND));
      send_byte({hi, 4'($urandom_range(0, 15))});
      send_byte(rand_data());
    end
    if (hi != mtep_pkg::HI_PROGRAM && hi != mtep_pkg::HI_CHAN_PRESS)
      send_byte(rand_data());
  endtask

  task automatic send_meta_event();
    logic [7:0] mtype;
    int len;
    int pick;
    send_vlq(pick_delta());
    send_byte(mtep_pkg::STATUS_META);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      mtype = mtep_pkg::META_SEQNUM;
      len   = $urandom_range(0, 3);
    end else if (pick < 55) begin
      mtype = mtep_pkg::META_TRACK_NAME;
      len   = $urandom_range(0, 8);
    end else if (pick < 62) begin
      mtype = mtep_pkg::META_END_TRACK;
      len   = $urandom_range(0, 2);
    end else begin
      mtype = 8'($urandom_range(0, 255));
      len   = $urandom_range(0, 6);
    end
    if ($urandom_range(0, 19) == 0)
      len = $urandom_range(9, 140);  // upper end needs a two-byte length
    send_byte(mtype);
    send_vlq(len);
    repeat (len)
      send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_broken_sequence();
    case ($urandom_range(0, 4))
      0: repeat (4) send_byte(8'h80 | 8'($urandom_range(0, 127)));  // delta too long
      1: begin
        send_vlq(pick_delta());
        send_byte(8'($urandom_range(mtep_pkg::STATUS_SYSTEM, STATUS_LAST_SYSTEM)));
      end
      2: begin
        new_track = 1'b1;  // fresh track has no running status
        send_vlq(pick_delta());
        send_byte(8'($urandom_range(0, 127)));
      end
      3: begin
        send_vlq(pick_delta());
        send_byte(mtep_pkg::STATUS_META);
        send_byte(8'($urandom_range(0, 255)));
        repeat (4) send_byte(8'h80 | 8'($urandom_range(0, 127)));
      end
      default: begin
        repeat ($urandom_range(2, 8)) begin
          new_track = ($urandom_range(0, 9) == 0);
          send_byte(8'($urandom_range(0, 255)));
        end
      end
    endcase
    // zero to three more bytes, into a halted parser in all but the random-bytes case
    repeat ($urandom_range(0, 3))
      send_byte(8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed events; restart the track whenever the parser is halted or mid-event, and now and then at random
  task automatic random_event();
    int pick;
    if (trk_halted || trk_phase != AWAIT_DELTA || $urandom_range(0, 49) == 0)
      new_track = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 62)
      send_channel_event();
    else if (pick < 88)
      send_meta_event();
    else
      send_broken_sequence();
  endtask

  // ---------------------------------------------------------------- receiver

  // Stall counted here, so a long hold-off runs while the sender keeps offering
  always @(negedge clk) begin
    if (rx_stall_left == 0) begin
      if (rx_hold_req != 0) begin
        rx_stall_left = rx_hold_req;
        rx_hold_req   = 0;
      end else if (rx_random && $urandom_range(0, 2) == 0) begin
        rx_stall_left = pick_gap();
      end
    end
    if (rx_stall_left > 0) begin
      out_stall <= 1'b1;
      rx_stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic cmp_field(input string fname, input logic [27:0] want, input logic [27:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin : event_checker
    mtep_pkg::event_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected event word, kind %0d", $time, event_kind);
      end else begin
        want = pending_events.pop_front();
        events_checked++;
        if (want.kind == mtep_pkg::KIND_ERROR)
          error_events++;
        cmp_field("event_kind", 28'(want.kind), 28'(event_kind));
        cmp_field("delta_time", want.delta, delta_time);
        cmp_field("channel", 28'(want.chan), 28'(channel));
        cmp_field("first_data", 28'(want.first), 28'(first_data));
        cmp_field("second_data", 28'(want.second), 28'(second_data));
        cmp_field("wide_value", 28'(want.wide), 28'(wide_value));
        cmp_field("meta_code", 28'(want.mtype), 28'(meta_code));
        cmp_field("payload_byte", 28'(want.pbyte), 28'(payload_byte));
      end
    end
  end

  // Watchdog: a run that stops moving words is a failure
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d events outstanding", $time,
               WATCHDOG_LIMIT, pending_events.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // Note on with zero velocity, largest delta, bend with top bits set, running status
  task automatic test_channel_basics();
    new_track = 1'b1;
    send_byte(8'h00); send_byte(8'h90); send_byte(8'h3C); send_byte(8'h00);
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h7F);
    send_byte(8'hEF); send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'h00); send_byte(8'h7F); send_byte(8'h40);
  endtask

  // One-byte sequence number; meta drops running status so the next data byte
  // errors and the stray byte after it is ignored; end of track with a payload
  task automatic test_meta_and_halt();
    send_byte(8'h00); send_byte(mtep_pkg::STATUS_META); send_byte(mtep_pkg::META_SEQNUM);
    send_byte(8'h01); send_byte(8'hAB);
    send_byte(8'h00); send_byte(8'h45); send_byte(8'h55);
    new_track = 1'b1;
    send_byte(8'h00); send_byte(mtep_pkg::STATUS_META); send_byte(mtep_pkg::META_END_TRACK);
    send_byte(8'h01); send_byte(8'h33); send_byte(8'h44);
  endtask

  // Delta with a fifth byte pending, then a system status byte
  task automatic test_fatal_bytes();
    new_track = 1'b1;
    send_byte(8'h80); send_byte(8'h80); send_byte(8'h80); send_byte(8'h80);
    new_track = 1'b1;
    send_byte(8'h00); send_byte(mtep_pkg::STATUS_SYSTEM);
  endtask

  task automatic test_random_tracks(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    tx_gaps   = 1'b1;
    rx_random = 1'b1;
    while (bytes_sent < stop_at)
      random_event();
  endtask

  task automatic test_back_to_back(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    tx_gaps   = 1'b0;
    rx_random = 1'b0;
    while (bytes_sent < stop_at)
      random_event();
  endtask

  // Receiver holds off long enough that the output fills and the input stalls
  task automatic test_output_backpressure();
    tx_gaps     = 1'b0;
    rx_random   = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    repeat (40)
      random_event();
    wait_for_events();
  endtask

  initial begin
    clear_track_state();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_gaps   = 1'b1;
    rx_random = 1'b1;
    test_channel_basics();
    test_meta_and_halt();
    test_fatal_bytes();
    wait_for_events();

    test_random_tracks(800);
    test_back_to_back(150);
    test_output_backpressure();
    test_random_tracks(250);

    wait_for_events();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d track bytes over %0d track starts; %0d events checked, %0d errors",
             bytes_sent, tracks_started, events_checked, error_events);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mtep_pkg.sv
rtl/midi_track_event_parser_top.sv
tb/sv/testbench.sv
